>>> sv/rled_pkg.sv
// Shared constants, codes and control/status types for the run-length image decoder.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package rled_pkg;

  // Field widths of the stream, result and configuration ports and of the bit buffer.
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned PIX_W      = 32;
  localparam int unsigned CNT_W      = 15;
  localparam int unsigned ST_W       = 3;
  localparam int unsigned TOT_W      = 25;
  localparam int unsigned BUF_W      = 16;
  localparam int unsigned HELD_W     = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 25;

  // Decode phases of the stream parser.
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_HIGH   = 3'd1;
  localparam logic [2:0] PH_PIXEL  = 3'd2;
  localparam logic [2:0] PH_DONE   = 3'd3;
  localparam logic [2:0] PH_ERROR  = 3'd4;

  // Frame types carried in the two low header bits.
  localparam logic [1:0] KIND_ZERO    = 2'b00;
  localparam logic [1:0] KIND_LITERAL = 2'b01;
  localparam logic [1:0] KIND_SHORT   = 2'b10;
  localparam logic [1:0] KIND_LONG    = 2'b11;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_RUN         = 3'd0;
  localparam logic [ST_W-1:0] ST_COMPLETE    = 3'd1;
  localparam logic [ST_W-1:0] ST_FRAME_ERR   = 3'd2;
  localparam logic [ST_W-1:0] ST_PIXEL_TRUNC = 3'd3;
  localparam logic [ST_W-1:0] ST_LONG_TRUNC  = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_INDEXED_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_BYTES  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PIXELS = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // take the accepted byte into the bit buffer
    logic step;       // commit one decode step
    logic push;       // move the held result into the output register
    logic push_last;  // the pushed result closes the current byte
  } rled_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic it_emit;     // the pending decode step produces a result
    logic it_end;      // the pending decode step finishes the current byte
    logic pend_valid;  // a result is held waiting for its last flag
    logic out_free;    // the output register can take a result this cycle
  } rled_stat_t;

endpackage

`default_nettype wire

>>> sv/rled_ifs.sv
// Valid/ready channel interfaces for the compressed byte input and the result output.
// Depends on rled_pkg for the field widths.
`default_nettype none

interface rled_in_if
  import rled_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface rled_out_if
  import rled_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;
  logic [CNT_W-1:0] repeat_count;
  logic [ST_W-1:0]  status;
  logic             last;

  modport source (output valid, output pixel_value, output repeat_count, output status,
                  output last, input ready);
  modport sink   (input valid, input pixel_value, input repeat_count, input status,
                  input last, output ready);
endinterface

`default_nettype wire

>>> sv/rled_ctrl.sv
// Controller of the run-length image decoder: sequences accept, decode steps and flush.
// Depends on rled_pkg for the command and status types.
`default_nettype none

module rled_ctrl
  import rled_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire rled_stat_t stat,
  output rled_cmd_t       cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        // A new result may only replace the held one if that one can move on.
        if (!(stat.it_emit && stat.pend_valid && !stat.out_free)) begin
          cmd.step = 1'b1;
          cmd.push = stat.it_emit && stat.pend_valid;
          if (stat.it_end) begin
            state_next = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (!stat.pend_valid) begin
          state_next = S_IDLE;
        end else if (stat.out_free) begin
          cmd.push      = 1'b1;
          cmd.push_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/rled_dp.sv
// Datapath of the run-length image decoder (needs rled_pkg): configuration, bit buffer,
// frame state, one decode step per cycle unless stalled, held result, output register.
`default_nettype none

module rled_dp
  import rled_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wen,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [BYTE_W-1:0]     data_byte,
  input  wire logic                  end_of_stream,
  input  wire rled_cmd_t             cmd,
  output rled_stat_t                 stat,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [PIX_W-1:0]           pixel_value,
  output logic [CNT_W-1:0]           repeat_count,
  output logic [ST_W-1:0]            status,
  output logic                       last
);

  // Configuration registers.
  logic             indexed_mode;
  logic [3:0]       index_bits;
  logic [2:0]       color_bytes;
  logic [TOT_W-1:0] total_pixels;

  // Decoder state.
  logic [BUF_W-1:0]  bit_buffer, bit_buffer_next;
  logic [HELD_W-1:0] bits_held, bits_held_next;
  logic [2:0]        decode_phase, decode_phase_next;
  logic [1:0]        frame_kind, frame_kind_next;
  logic [CNT_W-1:0]  frame_count, frame_count_next;
  logic [PIX_W-1:0]  color_acc, color_acc_next;
  logic [2:0]        color_taken, color_taken_next;
  logic [TOT_W-1:0]  pixels_emitted, pixels_emitted_next;
  logic              eos;

  // Held result, waiting to learn whether it closes the byte.
  logic             pend_valid;
  logic [PIX_W-1:0] pend_value;
  logic [CNT_W-1:0] pend_count;
  logic [ST_W-1:0]  pend_status;

  // Step outputs.
  logic             it_emit, it_end;
  logic [PIX_W-1:0] r_value;
  logic [CNT_W-1:0] r_count;
  logic [ST_W-1:0]  r_status;

  // Step intermediates.
  logic [3:0]        eff_ib;
  logic [2:0]        eff_cb;
  logic [3:0]        tk_n;
  logic              have;
  logic [HELD_W-1:0] tk_rest;
  logic [BUF_W-1:0]  tk_mask;
  logic [BYTE_W-1:0] tk_val;
  logic [BUF_W-1:0]  buf_rest;
  logic [5:0]        hdr_n;
  logic [CNT_W-1:0]  cnt_long, cnt_hdr, run_cnt;
  logic              run_over;
  logic              complete;
  logic [PIX_W-1:0]  acc_t;
  logic [2:0]        taken_t;
  logic              px_fire;
  logic [PIX_W-1:0]  px_value;
  logic [CNT_W-1:0]  lit_left;
  logic              do_fail;
  logic [ST_W-1:0]   fail_status;

  // Effective field sizes with out-of-range values clamped.
  always_comb begin
    eff_ib = index_bits;
    if (index_bits == 4'd0) begin
      eff_ib = 4'd1;
    end else if (index_bits > 4'd8) begin
      eff_ib = 4'd8;
    end
    eff_cb = color_bytes;
    if (color_bytes == 3'd0) begin
      eff_cb = 3'd1;
    end else if (color_bytes > 3'd4) begin
      eff_cb = 3'd4;
    end
  end

  // Bit field extraction: the top tk_n of the bits held, MSB first.
  always_comb begin
    tk_n     = (decode_phase == PH_PIXEL && indexed_mode) ? eff_ib : 4'd8;
    have     = bits_held >= HELD_W'(tk_n);
    tk_rest  = bits_held - HELD_W'(tk_n);
    tk_mask  = (BUF_W'(1) << tk_n) - BUF_W'(1);
    tk_val   = BYTE_W'((bit_buffer >> tk_rest) & tk_mask);
    buf_rest = bit_buffer & ((BUF_W'(1) << tk_rest) - BUF_W'(1));
  end

  // Run length of the frame being opened and its bound against the image size.
  always_comb begin
    hdr_n    = tk_val[7:2];
    cnt_long = CNT_W'({tk_val, frame_count[5:0]}) + CNT_W'(1);
    cnt_hdr  = (tk_val[1:0] == KIND_ZERO) ? CNT_W'(hdr_n) : CNT_W'(hdr_n) + CNT_W'(1);
    run_cnt  = (decode_phase == PH_HIGH) ? cnt_long : cnt_hdr;
    run_over = ({1'b0, pixels_emitted} + (TOT_W + 1)'(run_cnt)) > {1'b0, total_pixels};
    complete = pixels_emitted >= total_pixels;
  end

  // Raw colour byte gathering, first byte in the low bits.
  always_comb begin
    acc_t   = color_acc;
    taken_t = color_taken;
    if (color_taken < eff_cb) begin
      acc_t   = color_acc | (PIX_W'(tk_val) << {color_taken[1:0], 3'b000});
      taken_t = color_taken + 3'd1;
    end
  end

  // One decode step.
  always_comb begin
    bit_buffer_next     = bit_buffer;
    bits_held_next      = bits_held;
    decode_phase_next   = decode_phase;
    frame_kind_next     = frame_kind;
    frame_count_next    = frame_count;
    color_acc_next      = color_acc;
    color_taken_next    = color_taken;
    pixels_emitted_next = pixels_emitted;
    it_emit             = 1'b0;
    it_end              = 1'b0;
    r_value             = '0;
    r_count             = '0;
    r_status            = ST_RUN;
    px_fire             = 1'b0;
    px_value            = '0;
    do_fail             = 1'b0;
    fail_status         = ST_FRAME_ERR;
    lit_left            = frame_count - CNT_W'(1);

    unique case (decode_phase)
      PH_HEADER: begin
        if (complete) begin
          it_emit           = 1'b1;
          it_end            = 1'b1;
          r_status          = ST_COMPLETE;
          decode_phase_next = PH_DONE;
          bit_buffer_next   = '0;
          bits_held_next    = '0;
        end else if (!have) begin
          it_end  = 1'b1;
          do_fail = eos;
        end else begin
          bit_buffer_next = buf_rest;
          bits_held_next  = tk_rest;
          frame_kind_next = tk_val[1:0];
          if (tk_val[1:0] == KIND_LONG) begin
            frame_count_next  = CNT_W'(hdr_n);
            decode_phase_next = PH_HIGH;
          end else if (tk_val[1:0] == KIND_ZERO) begin
            if (hdr_n == 6'd0 || run_over) begin
              do_fail = 1'b1;
            end else begin
              it_emit             = 1'b1;
              r_count             = CNT_W'(hdr_n);
              pixels_emitted_next = pixels_emitted + TOT_W'(hdr_n);
            end
          end else if (run_over) begin
            do_fail = 1'b1;
          end else begin
            frame_count_next  = run_cnt;
            color_acc_next    = '0;
            color_taken_next  = '0;
            decode_phase_next = PH_PIXEL;
          end
        end
      end
      PH_HIGH: begin
        if (!have) begin
          it_end      = 1'b1;
          do_fail     = eos;
          fail_status = ST_LONG_TRUNC;
        end else begin
          bit_buffer_next = buf_rest;
          bits_held_next  = tk_rest;
          if (run_over) begin
            do_fail = 1'b1;
          end else begin
            frame_count_next  = run_cnt;
            color_acc_next    = '0;
            color_taken_next  = '0;
            decode_phase_next = PH_PIXEL;
          end
        end
      end
      PH_PIXEL: begin
        fail_status = ST_PIXEL_TRUNC;
        if (indexed_mode) begin
          if (!have) begin
            it_end  = 1'b1;
            do_fail = eos;
          end else begin
            bit_buffer_next = buf_rest;
            bits_held_next  = tk_rest;
            px_fire         = 1'b1;
            px_value        = PIX_W'(tk_val);
          end
        end else if (color_taken < eff_cb && !have) begin
          it_end  = 1'b1;
          do_fail = eos;
        end else begin
          if (color_taken < eff_cb) begin
            bit_buffer_next = buf_rest;
            bits_held_next  = tk_rest;
          end
          if (taken_t < eff_cb) begin
            color_acc_next   = acc_t;
            color_taken_next = taken_t;
          end else begin
            color_acc_next   = '0;
            color_taken_next = '0;
            px_fire          = 1'b1;
            px_value         = acc_t;
          end
        end
      end
      PH_DONE, PH_ERROR: begin
        it_end = 1'b1;
      end
      default: begin
        it_end = 1'b1;
      end
    endcase

    // A finished pixel: literal frames give one result per pixel, runs give one.
    if (px_fire) begin
      it_emit = 1'b1;
      r_value = px_value;
      if (frame_kind == KIND_LITERAL) begin
        r_count             = CNT_W'(1);
        pixels_emitted_next = pixels_emitted + TOT_W'(1);
        frame_count_next    = lit_left;
        if (lit_left == '0) begin
          decode_phase_next = PH_HEADER;
        end
      end else begin
        r_count             = frame_count;
        pixels_emitted_next = pixels_emitted + TOT_W'(frame_count);
        frame_count_next    = '0;
        decode_phase_next   = PH_HEADER;
      end
    end

    // Any error stops decoding until reset.
    if (do_fail) begin
      it_emit           = 1'b1;
      it_end            = 1'b1;
      r_value           = '0;
      r_count           = '0;
      r_status          = fail_status;
      decode_phase_next = PH_ERROR;
      bit_buffer_next   = '0;
      bits_held_next    = '0;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      indexed_mode <= 1'b1;
      index_bits   <= 4'd8;
      color_bytes  <= 3'd2;
      total_pixels <= TOT_W'(1);
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_INDEXED_MODE: indexed_mode <= cfg_data[0];
        CFG_INDEX_BITS:   index_bits   <= cfg_data[3:0];
        CFG_COLOR_BYTES:  color_bytes  <= cfg_data[2:0];
        CFG_TOTAL_PIXELS: total_pixels <= cfg_data[TOT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Decoder state: bytes are shifted in on load, steps commit one at a time.
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_buffer     <= '0;
      bits_held      <= '0;
      decode_phase   <= PH_HEADER;
      frame_kind     <= '0;
      frame_count    <= '0;
      color_acc      <= '0;
      color_taken    <= '0;
      pixels_emitted <= '0;
      eos            <= 1'b0;
    end else if (cmd.load) begin
      eos <= end_of_stream;
      if (decode_phase != PH_DONE && decode_phase != PH_ERROR) begin
        bit_buffer <= {bit_buffer[BUF_W-BYTE_W-1:0], data_byte};
        bits_held  <= bits_held + HELD_W'(BYTE_W);
      end
    end else if (cmd.step) begin
      bit_buffer     <= bit_buffer_next;
      bits_held      <= bits_held_next;
      decode_phase   <= decode_phase_next;
      frame_kind     <= frame_kind_next;
      frame_count    <= frame_count_next;
      color_acc      <= color_acc_next;
      color_taken    <= color_taken_next;
      pixels_emitted <= pixels_emitted_next;
    end
  end

  // Held result control.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.step && it_emit) begin
      pend_valid <= 1'b1;
    end else if (cmd.push) begin
      pend_valid <= 1'b0;
    end
  end

  // Held result payload.
  always_ff @(posedge clk) begin
    if (cmd.step && it_emit) begin
      pend_value  <= r_value;
      pend_count  <= r_count;
      pend_status <= r_status;
    end
  end

  // Output register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      pixel_value  <= pend_value;
      repeat_count <= pend_count;
      status       <= pend_status;
      last         <= cmd.push_last;
    end
  end

  // Status back to the controller.
  always_comb begin
    stat.it_emit    = it_emit;
    stat.it_end     = it_end;
    stat.pend_valid = pend_valid;
    stat.out_free   = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

>>> sv/rle_image_decoder.sv
// Run-length image decoder. A byte is taken while idle, then decoded one field per cycle
// (header, long-count high byte, palette index or raw colour byte), then closed by a step
// that finds the bits used up and a flush state. Results leave through an output register,
// and a stalled output holds the decoder only when a second result waits.
// Reset is synchronous, active high.
`default_nettype none

module rle_image_decoder
  import rled_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  rled_in_if.sink                    in_ch,
  rled_out_if.source                 out_ch,
  input  wire logic                  cfg_wen,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  rled_cmd_t  cmd;
  rled_stat_t stat;

  // Sequencing of accept, decode steps and flush.
  rled_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Parsing, configuration and result registers.
  rled_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .data_byte     (in_ch.data_byte),
    .end_of_stream (in_ch.end_of_stream),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .pixel_value   (out_ch.pixel_value),
    .repeat_count  (out_ch.repeat_count),
    .status        (out_ch.status),
    .last          (out_ch.last)
  );

`ifndef SYNTHESIS
  // A push always has a held result behind it.
  a_push_has_result: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> stat.pend_valid)
    else $error("result pushed with nothing held");

  // A new byte is only taken once the previous byte's results are flushed.
  a_idle_flushed: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !stat.pend_valid)
    else $error("byte accepted while a result is still held");

  // A held result is never overwritten without moving on.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && stat.it_emit && stat.pend_valid) |-> cmd.push)
    else $error("held result overwritten");

  // A pushed result shows at the output in the next cycle.
  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.push |=> out_ch.valid)
    else $error("pushed result not presented");
`endif

endmodule

`default_nettype wire

>>> sim/rle_image_decoder_tb.sv
// Self-checking testbench for rle_image_decoder: directed and random compressed byte streams.
// Depends on rled_pkg, the rled_in_if/rled_out_if interfaces and the rle_image_decoder RTL.
`default_nettype none

module rle_image_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rled_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              eos;
  } stream_byte_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic [CNT_W-1:0] repeat_count;
    logic [ST_W-1:0]  status;
    logic             last;
  } pixel_run_t;

  // Ways of closing the stream; only one is possible per run, as the
  // decoder stays idle after completion or an error until reset.
  typedef enum int {
    END_FILL, END_LOWER, END_ZERO_COUNT, END_OVERRUN,
    END_EOS_HEADER, END_EOS_HIGH, END_EOS_PIXEL
  } stream_end_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rled_in_if  in_ch ();
  rled_out_if out_ch ();

  rle_image_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  stream_byte_t byte_queue[$];
  pixel_run_t   runs_due[$];

  int mismatches     = 0;
  int bytes_made     = 0;
  int bytes_accepted = 0;
  int send_idle_pct  = 24;
  int recv_idle_pct  = 87;
  bit byte_taken     = 1'b0;
  int hold_left      = 0;
  bit hold_armed     = 1'b1;

  // Register copies, at their reset values.
  logic             cfg_indexed = 1'b1;
  logic [3:0]       cfg_ib      = 4'd8;
  logic [2:0]       cfg_cb      = 3'd2;
  logic [TOT_W-1:0] cfg_total   = TOT_W'(1);

  // Decoder state as the prediction sees it.
  logic [BUF_W-1:0] pend_bits   = '0;
  int unsigned      pend_len    = 0;
  logic [2:0]       parse_phase = PH_HEADER;
  logic [1:0]       cur_kind    = KIND_ZERO;
  int unsigned      cur_count   = 0;
  logic [31:0]      color_acc   = '0;
  int unsigned      color_taken = 0;
  int unsigned      pixels_out  = 0;

  // Bit packer for the stream under construction, MSB first.
  logic [31:0] gen_bits = '0;
  int          gen_len  = 0;

  always #5 clk = ~clk;

  function automatic int unsigned eff_index_bits();
    if (cfg_ib == 4'd0) return 1;
    if (cfg_ib > 4'd8) return 8;
    return cfg_ib;
  endfunction

  function automatic int unsigned eff_color_bytes();
    if (cfg_cb == 3'd0) return 1;
    if (cfg_cb > 3'd4) return 4;
    return cfg_cb;
  endfunction

  // Removes the n oldest held bits from the bit buffer and returns them.
  function automatic logic [7:0] pull_bits(input int unsigned n);
    int unsigned rest;
    logic [7:0]  v;
    rest = pend_len - n;
    v = 8'((pend_bits >> rest) & ((16'd1 << n) - 16'd1));
    pend_len = rest;
    pend_bits &= (16'd1 << rest) - 16'd1;
    return v;
  endfunction

  function automatic void add_run(input logic [31:0] value, input int unsigned count,
                                  input logic [ST_W-1:0] status);
    runs_due.push_back('{value, count[CNT_W-1:0], status, 1'b0});
  endfunction

  function automatic void abort_stream(input logic [ST_W-1:0] status);
    add_run('0, 0, status);
    parse_phase = PH_ERROR;
    pend_bits = '0;
    pend_len = 0;
  endfunction

  // Works out the results that one accepted stream byte causes.
  function automatic void decode_byte(input logic [7:0] data, input logic eos);
    int          first;
    int unsigned ib, cb, n, cnt, hi, b8;
    logic [7:0]  hdr;
    logic [31:0] value;
    pixel_run_t  r;
    if (parse_phase == PH_DONE || parse_phase == PH_ERROR) return;
    first = runs_due.size();
    ib = eff_index_bits();
    cb = eff_color_bytes();
    pend_bits = {pend_bits[7:0], data};
    pend_len += 8;
    while (1'b1) begin
      if (parse_phase == PH_HEADER) begin
        // The image is complete before any further header is read.
        if (pixels_out >= cfg_total) begin
          add_run('0, 0, ST_COMPLETE);
          parse_phase = PH_DONE;
          pend_bits = '0;
          pend_len = 0;
          break;
        end
        if (pend_len < 8) break;
        hdr = pull_bits(8);
        cur_kind = hdr[1:0];
        n = hdr[7:2];
        if (cur_kind == KIND_LONG) begin
          cur_count = n;
          parse_phase = PH_HIGH;
          continue;
        end
        if (cur_kind == KIND_ZERO) begin
          if (n == 0 || pixels_out + n > cfg_total) begin
            abort_stream(ST_FRAME_ERR);
            break;
          end
          add_run('0, n, ST_RUN);
          pixels_out += n;
          continue;
        end
        if (pixels_out + n + 1 > cfg_total) begin
          abort_stream(ST_FRAME_ERR);
          break;
        end
        cur_count = n + 1;
        color_acc = '0;
        color_taken = 0;
        parse_phase = PH_PIXEL;
      end else if (parse_phase == PH_HIGH) begin
        if (pend_len < 8) break;
        hi = pull_bits(8);
        cnt = ((cur_count & 32'h3F) | (hi << 6)) + 1;
        if (pixels_out + cnt > cfg_total) begin
          abort_stream(ST_FRAME_ERR);
          break;
        end
        cur_count = cnt;
        color_acc = '0;
        color_taken = 0;
        parse_phase = PH_PIXEL;
      end else begin
        if (cfg_indexed) begin
          if (pend_len < ib) break;
          value = pull_bits(ib);
        end else begin
          // Raw colour: bytes gather low byte first until the pixel is whole.
          if (color_taken < cb) begin
            if (pend_len < 8) break;
            b8 = pull_bits(8);
            color_acc |= b8 << (8 * (color_taken & 3));
            color_taken++;
          end
          if (color_taken < cb) continue;
          value = color_acc;
          color_acc = '0;
          color_taken = 0;
        end
        if (cur_kind == KIND_LITERAL) begin
          add_run(value, 1, ST_RUN);
          pixels_out += 1;
          cur_count = (cur_count - 1) & 32'h7FFF;
          if (cur_count == 0) parse_phase = PH_HEADER;
        end else begin
          add_run(value, cur_count, ST_RUN);
          pixels_out += cur_count;
          cur_count = 0;
          parse_phase = PH_HEADER;
        end
      end
    end
    // A stream that ends short is reported by what the decoder was waiting for.
    if (eos && parse_phase != PH_DONE && parse_phase != PH_ERROR) begin
      if (parse_phase == PH_HIGH) abort_stream(ST_LONG_TRUNC);
      else if (parse_phase == PH_PIXEL) abort_stream(ST_PIXEL_TRUNC);
      else abort_stream(ST_FRAME_ERR);
    end
    if (runs_due.size() > first) begin
      r = runs_due.pop_back();
      r.last = 1'b1;
      runs_due.push_back(r);
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Stream construction.
  function automatic void push_byte(input logic [7:0] data, input logic eos);
    byte_queue.push_back('{data, eos});
    bytes_made++;
  endfunction

  function automatic void put_bits(input logic [7:0] v, input int n);
    logic [7:0] top;
    gen_bits = (gen_bits << n) | ({24'd0, v} & ((32'd1 << n) - 32'd1));
    gen_len += n;
    while (gen_len >= 8) begin
      gen_len -= 8;
      top = 8'(gen_bits >> gen_len);
      push_byte(top, 1'b0);
      gen_bits &= (32'd1 << gen_len) - 32'd1;
    end
  endfunction

  function automatic void header(input logic [1:0] kind, input int unsigned n);
    put_bits({n[5:0], kind}, 8);
  endfunction

  function automatic void put_pixel();
    if (cfg_indexed) put_bits(8'($urandom), eff_index_bits());
    else repeat (eff_color_bytes()) put_bits(8'($urandom), 8);
  endfunction

  function automatic void put_frame(input logic [1:0] kind, input int unsigned n);
    header(kind, n);
    if (kind == KIND_LONG) put_bits(8'($urandom), 8);
    if (kind == KIND_LITERAL) repeat (n + 1) put_pixel();
    else if (kind != KIND_ZERO) put_pixel();
  endfunction

  function automatic void add_random_frame();
    logic [1:0]  kind;
    int unsigned n;
    kind = 2'($urandom_range(3));
    n = $urandom_range(63);
    if (kind == KIND_ZERO && n == 0) n = 1;
    // Long literal frames only where pixels are a bit or two wide.
    if (kind == KIND_LITERAL) begin
      if (cfg_indexed && eff_index_bits() <= 2 && $urandom_range(7) == 0) n = $urandom_range(63);
      else n = $urandom_range(7);
    end
    put_frame(kind, n);
  endfunction

  // Pads with a literal frame so that the stream ends on a byte boundary.
  function automatic void align_stream();
    int p;
    if (gen_len != 0) begin
      p = 1;
      while ((gen_len + p * eff_index_bits()) % 8 != 0) p++;
      put_frame(KIND_LITERAL, p - 1);
    end
  endfunction

  function automatic void mark_stream_end();
    stream_byte_t b;
    b = byte_queue.pop_back();
    b.eos = 1'b1;
    byte_queue.push_back(b);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      CFG_INDEXED_MODE: cfg_indexed = val[0];
      CFG_INDEX_BITS:   cfg_ib = val[3:0];
      CFG_COLOR_BYTES:  cfg_cb = val[2:0];
      default:          cfg_total = val[TOT_W-1:0];
    endcase
  endtask

  task automatic set_format(input logic indexed, input logic [3:0] ib, input logic [2:0] cb,
                            input logic [TOT_W-1:0] total);
    write_reg(CFG_INDEXED_MODE, indexed);
    write_reg(CFG_INDEX_BITS, ib);
    write_reg(CFG_COLOR_BYTES, cb);
    write_reg(CFG_TOTAL_PIXELS, total);
  endtask

  // Waits until every byte is taken and every result has arrived, then lets
  // a byte that causes no result finish its decode.
  task automatic settle();
    while (byte_queue.size() != 0 || in_ch.valid || runs_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Output checking and input prediction, both on the rising edge.
  always @(posedge clk) begin
    pixel_run_t want;
    if (rst) begin
      byte_taken = 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (runs_due.size() == 0) begin
          $error("unexpected result: pixel_value %0h repeat_count %0d status %0d last %0d",
                 out_ch.pixel_value, out_ch.repeat_count, out_ch.status, out_ch.last);
          mismatches++;
        end else begin
          want = runs_due.pop_front();
          check_field("pixel_value", want.pixel_value, out_ch.pixel_value);
          check_field("repeat_count", want.repeat_count, out_ch.repeat_count);
          check_field("status", want.status, out_ch.status);
          check_field("last", want.last, out_ch.last);
        end
      end
      byte_taken = in_ch.valid && in_ch.ready;
      if (byte_taken) begin
        bytes_accepted++;
        decode_byte(in_ch.data_byte, in_ch.end_of_stream);
      end
    end
  end

  // Byte driver: offers the next queued byte once the last transaction is done.
  always @(negedge clk) begin
    stream_byte_t next_byte;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || byte_taken) begin
      if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_byte = byte_queue.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= next_byte.data;
        in_ch.end_of_stream <= next_byte.eos;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver, with one long hold-off so that the decoder backs up.
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (hold_armed && bytes_accepted >= 30) begin
      hold_armed = 1'b0;
      hold_left = 400;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    stream_end_t      ending;
    int unsigned      left, n;
    int               random_start, target, phase;
    logic [1:0]       kind;
    logic [TOT_W-1:0] total;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.end_of_stream = 1'b0;
    out_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed frames: every frame type, with both count extremes of zero and long frames, in indexed mode.
    set_format(1'b1, 4'd8, 3'd2, 25'h1000000);
    header(KIND_ZERO, 1);
    header(KIND_ZERO, 63);
    header(KIND_LITERAL, 2);
    put_bits(8'hFF, 8);
    put_bits(8'h80, 8);
    put_bits(8'h01, 8);
    header(KIND_SHORT, 63);
    put_bits(8'hAA, 8);
    header(KIND_LONG, 63);
    put_bits(8'hFF, 8);
    put_bits(8'h55, 8);
    header(KIND_LONG, 0);
    put_bits(8'h00, 8);
    put_bits(8'h7F, 8);

    // Switch from indices to raw colour in the middle of a literal frame.
    header(KIND_LITERAL, 1);
    put_bits(8'h3C, 8);
    settle();
    write_reg(CFG_COLOR_BYTES, CFG_DATA_W'(1));
    write_reg(CFG_INDEXED_MODE, CFG_DATA_W'(0));
    put_bits(8'hC3, 8);

    // Widest raw colour, then shrink the colour size while a pixel is half read.
    settle();
    set_format(1'b0, 4'd8, 3'd4, 25'h1000000);
    header(KIND_SHORT, 0);
    repeat (4) put_bits(8'hFF, 8);
    header(KIND_SHORT, 5);
    put_bits(8'h12, 8);
    put_bits(8'h34, 8);
    settle();
    write_reg(CFG_COLOR_BYTES, CFG_DATA_W'(2));
    header(KIND_ZERO, 2);

    // Random frames, one pixel format per batch, batches ending on a frame boundary.
    random_start = bytes_made;
    phase = 0;
    while (bytes_made - random_start < 120) begin
      if (bytes_made - random_start < 40) begin
        send_idle_pct = 24;
        recv_idle_pct = 87;
      end else if (bytes_made - random_start < 80) begin
        send_idle_pct = 87;
        recv_idle_pct = 24;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      settle();
      case (phase)
        0: set_format(1'b1, 4'd1, 3'd2, 25'h1000000);
        1: set_format(1'b1, 4'd8, 3'd7, 25'h1FFFFFF);
        2: set_format(1'b0, 4'd0, 3'd1, 25'h1000000);
        3: set_format(1'b0, 4'd15, 3'd4, 25'h1FFFFFF);
        default: set_format(1'($urandom_range(1)), 4'($urandom_range(15)),
                            3'($urandom_range(7)), phase[0] ? 25'h1FFFFFF : 25'h1000000);
      endcase
      target = bytes_made + $urandom_range(15, 30);
      while (bytes_made < target) add_random_frame();
      align_stream();
      phase++;
    end

    // Close the image one way or another, then send bytes that must be ignored.
    settle();
    write_reg(CFG_INDEXED_MODE, CFG_DATA_W'(1));
    write_reg(CFG_INDEX_BITS, CFG_DATA_W'(8));
    ending = stream_end_t'($urandom_range(6));
    case (ending)
      END_FILL: begin
        left = $urandom_range(1, 200);
        write_reg(CFG_TOTAL_PIXELS, TOT_W'(pixels_out + left));
        while (left > 0) begin
          n = $urandom_range(1, 63);
          if (n > left) n = left;
          header(KIND_ZERO, n);
          left -= n;
        end
        if ($urandom_range(1)) mark_stream_end();
      end
      END_LOWER: begin
        total = $urandom_range(1) ? '0 : TOT_W'($urandom_range(pixels_out));
        write_reg(CFG_TOTAL_PIXELS, total);
        put_bits(8'($urandom), 8);
      end
      END_ZERO_COUNT: header(KIND_ZERO, 0);
      END_OVERRUN: begin
        write_reg(CFG_TOTAL_PIXELS, TOT_W'(pixels_out + $urandom_range(1, 40)));
        kind = $urandom_range(1) ? KIND_ZERO : KIND_SHORT;
        header(kind, 63);
      end
      END_EOS_HEADER: begin
        header(KIND_ZERO, $urandom_range(1, 63));
        mark_stream_end();
      end
      END_EOS_HIGH: begin
        header(KIND_LONG, $urandom_range(63));
        mark_stream_end();
      end
      default: begin
        header(KIND_SHORT, $urandom_range(63));
        mark_stream_end();
      end
    endcase
    repeat (4) push_byte(8'($urandom), 1'($urandom_range(1)));

    while (byte_queue.size() != 0 || in_ch.valid || runs_due.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
